>>> hw/rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg - shared types and constants of the line editor
// Decoder phases, editing operations, sequencer states and key codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

  typedef enum logic [1:0] {
    PH_GROUND = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INSERT,
    OP_ACCEPT,
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_UP,
    OP_DOWN,
    OP_BKSP,
    OP_DEL,
    OP_EOF,
    OP_KILL_HEAD,
    OP_KILL_TAIL,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_PUT,
    ST_EXIT,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t        op;
    phase_t     phase;
    logic [7:0] csi_num;
    logic       csi_closed;
  } dec_t;

  typedef struct packed {
    logic       done;
    logic       dirty;
    logic       clr;
    logic [7:0] rd_data;
    phase_t     phase;
  } stat_t;

  localparam logic [1:0] CMD_KEY  = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_NEW  = 2'd2;

  localparam logic [7:0] KEY_CTRL_A    = 8'h01;
  localparam logic [7:0] KEY_CTRL_B    = 8'h02;
  localparam logic [7:0] KEY_CTRL_D    = 8'h04;
  localparam logic [7:0] KEY_CTRL_E    = 8'h05;
  localparam logic [7:0] KEY_CTRL_F    = 8'h06;
  localparam logic [7:0] KEY_BS        = 8'h08;
  localparam logic [7:0] KEY_LF        = 8'h0A;
  localparam logic [7:0] KEY_CTRL_K    = 8'h0B;
  localparam logic [7:0] KEY_CTRL_L    = 8'h0C;
  localparam logic [7:0] KEY_CR        = 8'h0D;
  localparam logic [7:0] KEY_CTRL_N    = 8'h0E;
  localparam logic [7:0] KEY_CTRL_P    = 8'h10;
  localparam logic [7:0] KEY_CTRL_U    = 8'h15;
  localparam logic [7:0] KEY_ESC       = 8'h1B;
  localparam logic [7:0] KEY_DEL       = 8'h7F;
  localparam logic [7:0] KEY_PRINT_LO  = 8'h20;
  localparam logic [7:0] KEY_PRINT_HI  = 8'h7E;
  localparam logic [7:0] KEY_LBRACKET  = 8'h5B;
  localparam logic [7:0] KEY_TILDE     = 8'h7E;
  localparam logic [7:0] KEY_DIGIT0    = 8'h30;
  localparam logic [7:0] KEY_DIGIT9    = 8'h39;
  localparam logic [7:0] CSI_FINAL_MIN = 8'h40;
  localparam logic [7:0] CSI_UP        = 8'h41;
  localparam logic [7:0] CSI_DOWN      = 8'h42;
  localparam logic [7:0] CSI_RIGHT     = 8'h43;
  localparam logic [7:0] CSI_LEFT      = 8'h44;
  localparam logic [7:0] CSI_END       = 8'h46;
  localparam logic [7:0] CSI_HOME      = 8'h48;

  localparam logic [7:0] TILDE_HOME1 = 8'd1;
  localparam logic [7:0] TILDE_DEL   = 8'd3;
  localparam logic [7:0] TILDE_END1  = 8'd4;
  localparam logic [7:0] TILDE_HOME2 = 8'd7;
  localparam logic [7:0] TILDE_END2  = 8'd8;
  localparam logic [7:0] CSI_NUM_MAX = 8'd255;

  localparam logic [31:0] EXIT_WORD = 32'h65786974;  // "exit"

endpackage

`default_nettype wire

>>> hw/rtl/lse_key_dec.sv
// ----------------------------------------------------------------------------
// lse_key_dec - escape sequence decoder
// Maps one key byte and the decoder phase to an editing operation.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_key_dec (
  input  wire logic [7:0]      key,
  input  wire lse_pkg::phase_t phase,
  input  wire logic [7:0]      csi_num,
  input  wire logic            csi_closed,
  output lse_pkg::dec_t        dec
);

  logic [11:0] csi_v;
  logic        use_ground;

  assign csi_v = 12'({csi_num, 3'b000}) + 12'({csi_num, 1'b0}) + 12'(key - lse_pkg::KEY_DIGIT0);

  always_comb begin
    dec.op         = lse_pkg::OP_NONE;
    dec.phase      = phase;
    dec.csi_num    = csi_num;
    dec.csi_closed = csi_closed;
    use_ground     = 1'b0;
    unique case (phase)
      lse_pkg::PH_ESC: begin
        if (key == lse_pkg::KEY_LBRACKET) begin
          dec.phase      = lse_pkg::PH_CSI;
          dec.csi_num    = '0;
          dec.csi_closed = 1'b0;
        end else begin
          dec.phase  = lse_pkg::PH_GROUND;
          use_ground = 1'b1;
        end
      end
      lse_pkg::PH_CSI: begin
        if (key < lse_pkg::CSI_FINAL_MIN) begin
          if (!csi_closed && key >= lse_pkg::KEY_DIGIT0 && key <= lse_pkg::KEY_DIGIT9) begin
            dec.csi_num = (csi_v > 12'(lse_pkg::CSI_NUM_MAX)) ? lse_pkg::CSI_NUM_MAX
                                                              : csi_v[7:0];
          end else begin
            dec.csi_closed = 1'b1;
          end
        end else begin
          dec.phase = lse_pkg::PH_GROUND;
          unique case (key)
            lse_pkg::CSI_UP:    dec.op = lse_pkg::OP_UP;
            lse_pkg::CSI_DOWN:  dec.op = lse_pkg::OP_DOWN;
            lse_pkg::CSI_RIGHT: dec.op = lse_pkg::OP_RIGHT;
            lse_pkg::CSI_LEFT:  dec.op = lse_pkg::OP_LEFT;
            lse_pkg::CSI_HOME:  dec.op = lse_pkg::OP_HOME;
            lse_pkg::CSI_END:   dec.op = lse_pkg::OP_END;
            lse_pkg::KEY_TILDE: begin
              if (csi_num == lse_pkg::TILDE_HOME1 || csi_num == lse_pkg::TILDE_HOME2) begin
                dec.op = lse_pkg::OP_HOME;
              end else if (csi_num == lse_pkg::TILDE_END1 ||
                           csi_num == lse_pkg::TILDE_END2) begin
                dec.op = lse_pkg::OP_END;
              end else if (csi_num == lse_pkg::TILDE_DEL) begin
                dec.op = lse_pkg::OP_DEL;
              end
            end
            default: dec.op = lse_pkg::OP_NONE;
          endcase
        end
      end
      default: use_ground = 1'b1;
    endcase

    if (use_ground) begin
      if (key >= lse_pkg::KEY_PRINT_LO && key <= lse_pkg::KEY_PRINT_HI) begin
        dec.op = lse_pkg::OP_INSERT;
      end else begin
        unique case (key)
          lse_pkg::KEY_ESC:    dec.phase = lse_pkg::PH_ESC;
          lse_pkg::KEY_CR,
          lse_pkg::KEY_LF:     dec.op = lse_pkg::OP_ACCEPT;
          lse_pkg::KEY_CTRL_B: dec.op = lse_pkg::OP_LEFT;
          lse_pkg::KEY_CTRL_F: dec.op = lse_pkg::OP_RIGHT;
          lse_pkg::KEY_CTRL_A: dec.op = lse_pkg::OP_HOME;
          lse_pkg::KEY_CTRL_E: dec.op = lse_pkg::OP_END;
          lse_pkg::KEY_CTRL_P: dec.op = lse_pkg::OP_UP;
          lse_pkg::KEY_CTRL_N: dec.op = lse_pkg::OP_DOWN;
          lse_pkg::KEY_BS,
          lse_pkg::KEY_DEL:    dec.op = lse_pkg::OP_BKSP;
          lse_pkg::KEY_CTRL_U: dec.op = lse_pkg::OP_KILL_HEAD;
          lse_pkg::KEY_CTRL_K: dec.op = lse_pkg::OP_KILL_TAIL;
          lse_pkg::KEY_CTRL_D: dec.op = lse_pkg::OP_EOF;
          lse_pkg::KEY_CTRL_L: dec.op = lse_pkg::OP_CLEAR;
          default:             dec.op = lse_pkg::OP_NONE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lse_line_ram.sv
// ----------------------------------------------------------------------------
// lse_line_ram - line buffer memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_line_ram #(
  parameter int LINE_LEN = 256
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(LINE_LEN)-1:0] waddr,
  input  wire logic [7:0]                  wdata,
  input  wire logic [$clog2(LINE_LEN)-1:0] raddr,
  output logic      [7:0]                  rdata
);

  logic [7:0] mem [LINE_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lse_hist_ram.sv
// ----------------------------------------------------------------------------
// lse_hist_ram - history line memory
// One row per history slot; one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_hist_ram #(
  parameter int LINE_LEN   = 256,
  parameter int HIST_DEPTH = 8
) (
  input  wire logic                                              clk,
  input  wire logic                                              we,
  input  wire logic [((HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1)-1:0] wslot,
  input  wire logic [$clog2(LINE_LEN)-1:0]                       waddr,
  input  wire logic [7:0]                                        wdata,
  input  wire logic [((HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1)-1:0] rslot,
  input  wire logic [$clog2(LINE_LEN)-1:0]                       raddr,
  output logic      [7:0]                                        rdata
);

  logic [7:0] mem [HIST_DEPTH][LINE_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wslot][waddr] <= wdata;
    end
    rdata <= mem[rslot][raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lse_ctrl.sv
// ----------------------------------------------------------------------------
// lse_ctrl - editor sequencer
// Applies one request to the line state and runs byte moves through memory.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ctrl #(
  parameter int LINE_LEN   = 256,
  parameter int HIST_DEPTH = 8,
  localparam int AW = $clog2(LINE_LEN),
  localparam int LW = $clog2(LINE_LEN + 1),
  localparam int SW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1,
  localparam int PW = $clog2(HIST_DEPTH + 1),
  localparam int CW = (LW > 8) ? LW : 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    command,
  input  wire logic [7:0]    key_byte,
  input  wire logic [7:0]    read_index,
  input  wire logic          out_free,
  output logic               push,
  output logic [LW-1:0]      st_len,
  output logic [LW-1:0]      st_cur,
  output lse_pkg::stat_t     st,
  output logic               line_we,
  output logic [AW-1:0]      line_wa,
  output logic [7:0]         line_wd,
  output logic [AW-1:0]      raddr,
  input  wire logic [7:0]    line_q,
  output logic               hist_we,
  output logic [AW-1:0]      hist_wa,
  output logic [7:0]         hist_wd,
  output logic [SW-1:0]      hslot,
  input  wire logic [7:0]    hist_q
);

  localparam logic [LW-1:0] LEN_MAX     = LW'(LINE_LEN);
  localparam logic [PW-1:0] H_NONE      = PW'(HIST_DEPTH);
  localparam logic [SW-1:0] H_LAST_SLOT = SW'(HIST_DEPTH - 1);
  localparam logic [PW:0]   H_WIDE      = (PW + 1)'(HIST_DEPTH);

  lse_pkg::state_t state, state_next;
  lse_pkg::phase_t phase, phase_next;
  lse_pkg::dec_t   dec;

  logic [LW-1:0] len, len_next, cur, cur_next;
  logic          done, done_next, dirty, dirty_next, clr, clr_next;
  logic [7:0]    csi_num, csi_num_next;
  logic          csi_closed, csi_closed_next;
  logic [SW-1:0] newest, newest_next;
  logic [PW-1:0] hcount, hcount_next, hpos, hpos_next;
  logic [7:0]    rd_data, rd_data_next, key_q, key_q_next;
  logic [AW-1:0] put_addr, put_addr_next;
  logic [AW-1:0] c_rd, c_rd_next, c_wr, c_wr_next, p_wa, p_wa_next;
  logic [LW-1:0] c_left, c_left_next;
  logic          c_desc, c_desc_next, c_src_hist, c_src_hist_next;
  logic          c_dst_hist, c_dst_hist_next, c_then_put, c_then_put_next;
  logic [SW-1:0] c_slot, c_slot_next;
  logic          p_vld, p_vld_next;
  logic [1:0]    exit_cnt, exit_cnt_next;

  logic [LW-1:0] hist_len [HIST_DEPTH];
  logic          hl_we;

  logic          acc, do_accept, do_load, do_del;
  logic [PW-1:0] up_age, dn_age, ld_age;
  logic [PW:0]   slot_sum;
  logic [SW-1:0] ld_slot, acc_slot;
  logic [LW-1:0] ld_n;
  logic [CW-1:0] idx_ext;

  lse_key_dec u_dec (
    .key        (key_byte),
    .phase      (phase),
    .csi_num    (csi_num),
    .csi_closed (csi_closed),
    .dec        (dec)
  );

  assign acc      = in_valid && (state == lse_pkg::ST_IDLE);
  assign in_stall = (state != lse_pkg::ST_IDLE);
  assign idx_ext  = CW'(read_index);

  // history slot arithmetic: age 0 is the newest entry
  assign up_age   = (hpos == H_NONE) ? '0
                  : ((PW'(hpos + PW'(1)) < hcount) ? PW'(hpos + PW'(1)) : hpos);
  assign dn_age   = PW'(hpos - PW'(1));
  assign ld_age   = (dec.op == lse_pkg::OP_DOWN) ? dn_age : up_age;
  assign slot_sum = (PW + 1)'((PW + 1)'(newest) + H_WIDE - (PW + 1)'(ld_age));
  assign ld_slot  = (slot_sum >= H_WIDE) ? SW'(slot_sum - H_WIDE) : SW'(slot_sum);
  assign ld_n     = hist_len[ld_slot];
  assign acc_slot = (hcount == '0) ? newest
                  : ((newest == H_LAST_SLOT) ? '0 : SW'(newest + SW'(1)));

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    len_next        = len;
    cur_next        = cur;
    done_next       = done;
    dirty_next      = dirty;
    clr_next        = clr;
    csi_num_next    = csi_num;
    csi_closed_next = csi_closed;
    newest_next     = newest;
    hcount_next     = hcount;
    hpos_next       = hpos;
    rd_data_next    = rd_data;
    key_q_next      = key_q;
    put_addr_next   = put_addr;
    c_rd_next       = c_rd;
    c_wr_next       = c_wr;
    c_left_next     = c_left;
    c_desc_next     = c_desc;
    c_src_hist_next = c_src_hist;
    c_dst_hist_next = c_dst_hist;
    c_then_put_next = c_then_put;
    c_slot_next     = c_slot;
    p_vld_next      = 1'b0;
    p_wa_next       = p_wa;
    exit_cnt_next   = exit_cnt;
    line_we         = 1'b0;
    line_wa         = p_wa;
    line_wd         = c_src_hist ? hist_q : line_q;
    hist_we         = 1'b0;
    hist_wa         = p_wa;
    hist_wd         = line_q;
    raddr           = c_rd;
    hslot           = c_slot;
    hl_we           = 1'b0;
    push            = 1'b0;
    do_accept       = 1'b0;
    do_load         = 1'b0;
    do_del          = 1'b0;

    unique case (state)
      lse_pkg::ST_IDLE: begin
        raddr = idx_ext[AW-1:0];
        if (acc) begin
          dirty_next   = 1'b0;
          clr_next     = 1'b0;
          rd_data_next = '0;
          state_next   = lse_pkg::ST_RESULT;
          unique case (command)
            lse_pkg::CMD_KEY: begin
              if (!done) begin
                phase_next      = dec.phase;
                csi_num_next    = dec.csi_num;
                csi_closed_next = dec.csi_closed;
                unique case (dec.op)
                  lse_pkg::OP_INSERT: begin
                    if (len != LEN_MAX) begin
                      // open a gap at the cursor from the top down, then drop the key in
                      c_src_hist_next = 1'b0;
                      c_dst_hist_next = 1'b0;
                      c_desc_next     = 1'b1;
                      c_then_put_next = 1'b1;
                      c_rd_next       = AW'(len - LW'(1));
                      c_wr_next       = AW'(len);
                      c_left_next     = len - cur;
                      put_addr_next   = AW'(cur);
                      key_q_next      = key_byte;
                      len_next        = len + LW'(1);
                      cur_next        = cur + LW'(1);
                      dirty_next      = 1'b1;
                      state_next      = lse_pkg::ST_COPY;
                    end
                  end
                  lse_pkg::OP_ACCEPT: do_accept = 1'b1;
                  lse_pkg::OP_LEFT: begin
                    if (cur != '0) begin
                      cur_next   = cur - LW'(1);
                      dirty_next = 1'b1;
                    end
                  end
                  lse_pkg::OP_RIGHT: begin
                    if (cur < len) begin
                      cur_next   = cur + LW'(1);
                      dirty_next = 1'b1;
                    end
                  end
                  lse_pkg::OP_HOME: begin
                    cur_next   = '0;
                    dirty_next = 1'b1;
                  end
                  lse_pkg::OP_END: begin
                    cur_next   = len;
                    dirty_next = 1'b1;
                  end
                  lse_pkg::OP_UP: begin
                    if (hcount != '0) begin
                      hpos_next = up_age;
                      do_load   = 1'b1;
                    end
                  end
                  lse_pkg::OP_DOWN: begin
                    if (hpos != H_NONE) begin
                      if (hpos == '0) begin
                        hpos_next  = H_NONE;
                        len_next   = '0;
                        cur_next   = '0;
                        dirty_next = 1'b1;
                      end else begin
                        hpos_next = dn_age;
                        do_load   = 1'b1;
                      end
                    end
                  end
                  lse_pkg::OP_BKSP: begin
                    if (cur != '0) begin
                      c_src_hist_next = 1'b0;
                      c_dst_hist_next = 1'b0;
                      c_desc_next     = 1'b0;
                      c_then_put_next = 1'b0;
                      c_rd_next       = AW'(cur);
                      c_wr_next       = AW'(cur - LW'(1));
                      c_left_next     = len - cur;
                      len_next        = len - LW'(1);
                      cur_next        = cur - LW'(1);
                      dirty_next      = 1'b1;
                      state_next      = lse_pkg::ST_COPY;
                    end
                  end
                  lse_pkg::OP_DEL: do_del = 1'b1;
                  lse_pkg::OP_EOF: begin
                    if (len == '0) begin
                      len_next      = LW'(4);
                      dirty_next    = 1'b1;
                      exit_cnt_next = '0;
                      state_next    = lse_pkg::ST_EXIT;
                    end else begin
                      do_del = 1'b1;
                    end
                  end
                  lse_pkg::OP_KILL_HEAD: begin
                    c_src_hist_next = 1'b0;
                    c_dst_hist_next = 1'b0;
                    c_desc_next     = 1'b0;
                    c_then_put_next = 1'b0;
                    c_rd_next       = AW'(cur);
                    c_wr_next       = '0;
                    c_left_next     = len - cur;
                    len_next        = len - cur;
                    cur_next        = '0;
                    dirty_next      = 1'b1;
                    state_next      = lse_pkg::ST_COPY;
                  end
                  lse_pkg::OP_KILL_TAIL: begin
                    len_next   = cur;
                    dirty_next = 1'b1;
                  end
                  lse_pkg::OP_CLEAR: begin
                    clr_next   = 1'b1;
                    dirty_next = 1'b1;
                  end
                  default: ;
                endcase
              end
            end
            lse_pkg::CMD_READ: begin
              if (idx_ext < CW'(len)) begin
                state_next = lse_pkg::ST_READ;
              end
            end
            lse_pkg::CMD_NEW: begin
              len_next   = '0;
              cur_next   = '0;
              phase_next = lse_pkg::PH_GROUND;
              done_next  = 1'b0;
              dirty_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      lse_pkg::ST_COPY: begin
        line_we = p_vld && !c_dst_hist;
        hist_we = p_vld && c_dst_hist;
        if (c_left != '0) begin
          p_vld_next  = 1'b1;
          p_wa_next   = c_wr;
          c_rd_next   = c_desc ? AW'(c_rd - AW'(1)) : AW'(c_rd + AW'(1));
          c_wr_next   = c_desc ? AW'(c_wr - AW'(1)) : AW'(c_wr + AW'(1));
          c_left_next = c_left - LW'(1);
        end else if (!p_vld) begin
          state_next = c_then_put ? lse_pkg::ST_PUT : lse_pkg::ST_RESULT;
        end
      end
      lse_pkg::ST_PUT: begin
        line_we    = 1'b1;
        line_wa    = put_addr;
        line_wd    = key_q;
        state_next = lse_pkg::ST_RESULT;
      end
      lse_pkg::ST_EXIT: begin
        line_we       = 1'b1;
        line_wa       = AW'(exit_cnt);
        line_wd       = lse_pkg::EXIT_WORD[{~exit_cnt, 3'b000} +: 8];
        exit_cnt_next = exit_cnt + 2'd1;
        if (exit_cnt == 2'd3) begin
          do_accept = 1'b1;
        end
      end
      lse_pkg::ST_READ: begin
        rd_data_next = line_q;
        state_next   = lse_pkg::ST_RESULT;
      end
      lse_pkg::ST_RESULT: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = lse_pkg::ST_IDLE;
        end
      end
      default: state_next = lse_pkg::ST_IDLE;
    endcase

    // delete under the cursor: pull the tail down by one
    if (do_del && cur < len) begin
      c_src_hist_next = 1'b0;
      c_dst_hist_next = 1'b0;
      c_desc_next     = 1'b0;
      c_then_put_next = 1'b0;
      c_rd_next       = AW'(cur + LW'(1));
      c_wr_next       = AW'(cur);
      c_left_next     = len - cur - LW'(1);
      len_next        = len - LW'(1);
      dirty_next      = 1'b1;
      state_next      = lse_pkg::ST_COPY;
    end

    // recall: copy the history row into the line
    if (do_load) begin
      c_src_hist_next = 1'b1;
      c_dst_hist_next = 1'b0;
      c_desc_next     = 1'b0;
      c_then_put_next = 1'b0;
      c_slot_next     = ld_slot;
      c_rd_next       = '0;
      c_wr_next       = '0;
      c_left_next     = ld_n;
      len_next        = ld_n;
      cur_next        = ld_n;
      dirty_next      = 1'b1;
      state_next      = lse_pkg::ST_COPY;
    end

    // accept: push the line into the ring, oldest slot is overwritten when full
    if (do_accept) begin
      done_next       = 1'b1;
      hl_we           = 1'b1;
      newest_next     = acc_slot;
      hcount_next     = (hcount == H_NONE) ? hcount : PW'(hcount + PW'(1));
      hpos_next       = H_NONE;
      c_src_hist_next = 1'b0;
      c_dst_hist_next = 1'b1;
      c_desc_next     = 1'b0;
      c_then_put_next = 1'b0;
      c_slot_next     = acc_slot;
      c_rd_next       = '0;
      c_wr_next       = '0;
      c_left_next     = len;
      state_next      = lse_pkg::ST_COPY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lse_pkg::ST_IDLE;
      phase      <= lse_pkg::PH_GROUND;
      len        <= '0;
      cur        <= '0;
      done       <= 1'b0;
      dirty      <= 1'b0;
      clr        <= 1'b0;
      csi_num    <= '0;
      csi_closed <= 1'b0;
      newest     <= '0;
      hcount     <= '0;
      hpos       <= H_NONE;
      p_vld      <= 1'b0;
      c_left     <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      len        <= len_next;
      cur        <= cur_next;
      done       <= done_next;
      dirty      <= dirty_next;
      clr        <= clr_next;
      csi_num    <= csi_num_next;
      csi_closed <= csi_closed_next;
      newest     <= newest_next;
      hcount     <= hcount_next;
      hpos       <= hpos_next;
      p_vld      <= p_vld_next;
      c_left     <= c_left_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_data    <= rd_data_next;
    key_q      <= key_q_next;
    put_addr   <= put_addr_next;
    c_rd       <= c_rd_next;
    c_wr       <= c_wr_next;
    c_desc     <= c_desc_next;
    c_src_hist <= c_src_hist_next;
    c_dst_hist <= c_dst_hist_next;
    c_then_put <= c_then_put_next;
    c_slot     <= c_slot_next;
    p_wa       <= p_wa_next;
    exit_cnt   <= exit_cnt_next;
    if (hl_we) begin
      hist_len[acc_slot] <= len;
    end
  end

  assign st_len     = len;
  assign st_cur     = cur;
  assign st.done    = done;
  assign st.dirty   = dirty;
  assign st.clr     = clr;
  assign st.rd_data = rd_data;
  assign st.phase   = phase;

  a_cur_in_line: assert property (@(posedge clk) disable iff (rst) cur <= len)
    else $error("cursor beyond line end");
  a_len_bound: assert property (@(posedge clk) disable iff (rst) len <= LEN_MAX)
    else $error("line length over capacity");
  a_hpos_valid: assert property (@(posedge clk) disable iff (rst)
    (hpos != H_NONE) |-> (hpos < hcount))
    else $error("history position points past filled entries");
  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    (state != lse_pkg::ST_COPY) |-> !p_vld)
    else $error("copy write pending outside copy");

endmodule

`default_nettype wire

>>> hw/rtl/escape_sequence_line_editor.sv
// ----------------------------------------------------------------------------
// escape_sequence_line_editor - terminal line editor with history
// Key bytes edit a line buffer through an escape/CSI decoder; lines are
// saved to a history ring and recalled by up/down.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  cmd     | cmd_valid/cmd_stall| command, key_byte, read_index
//  res     | res_valid/res_stall| line_length, cursor_pos, accepted, redraw,
//          |                    | clear_screen, read_data, decoder_state
//
//  Cursor, decoder and kill-to-end requests go straight to the result
//  state, a read inside the line first reads the line memory. Delete,
//  kill-to-start, accept and history recall move bytes through the line or
//  history memory at one byte a cycle, insert then writes the key;
//  Ctrl-D on an empty line writes "exit" into the line and accepts it.
//  Reset: synchronous; no memory clearing pass, the block takes a request
//  in the first cycle after reset.
//  Stalls: one request is worked on at a time; a finished result sits in the
//  output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_line_editor #(
  parameter int LINE_LEN   = 256,
  parameter int HIST_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_stall,
  input  wire logic [1:0]                        command,
  input  wire logic [7:0]                        key_byte,
  input  wire logic [7:0]                        read_index,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic      [$clog2(LINE_LEN + 1)-1:0]   line_length,
  output logic      [$clog2(LINE_LEN + 1)-1:0]   cursor_pos,
  output logic                                   accepted,
  output logic                                   redraw,
  output logic                                   clear_screen,
  output logic      [7:0]                        read_data,
  output logic      [1:0]                        decoder_state
);

  localparam int AW = $clog2(LINE_LEN);
  localparam int LW = $clog2(LINE_LEN + 1);
  localparam int SW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  logic           push, out_free;
  logic [LW-1:0]  st_len, st_cur;
  lse_pkg::stat_t st;

  // line buffer port signals
  logic          line_we;
  logic [AW-1:0] line_wa, raddr;
  logic [7:0]    line_wd, line_q;

  // history port signals
  logic          hist_we;
  logic [AW-1:0] hist_wa;
  logic [7:0]    hist_wd, hist_q;
  logic [SW-1:0] hslot;

  // output register frees up when it is empty or being taken this cycle
  assign out_free = !res_valid || !res_stall;

  lse_ctrl #(
    .LINE_LEN   (LINE_LEN),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd_valid),
    .in_stall   (cmd_stall),
    .command    (command),
    .key_byte   (key_byte),
    .read_index (read_index),
    .out_free   (out_free),
    .push       (push),
    .st_len     (st_len),
    .st_cur     (st_cur),
    .st         (st),
    .line_we    (line_we),
    .line_wa    (line_wa),
    .line_wd    (line_wd),
    .raddr      (raddr),
    .line_q     (line_q),
    .hist_we    (hist_we),
    .hist_wa    (hist_wa),
    .hist_wd    (hist_wd),
    .hslot      (hslot),
    .hist_q     (hist_q)
  );

  lse_line_ram #(
    .LINE_LEN (LINE_LEN)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_wa),
    .wdata (line_wd),
    .raddr (raddr),
    .rdata (line_q)
  );

  // history rows share the read/write slot select of the copy engine
  lse_hist_ram #(
    .LINE_LEN   (LINE_LEN),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .wslot (hslot),
    .waddr (hist_wa),
    .wdata (hist_wd),
    .rslot (hslot),
    .raddr (raddr),
    .rdata (hist_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      line_length   <= st_len;
      cursor_pos    <= st_cur;
      accepted      <= st.done;
      redraw        <= st.dirty;
      clear_screen  <= st.clr;
      read_data     <= st.rd_data;
      decoder_state <= st.phase;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_escape_sequence_line_editor.sv
// ----------------------------------------------------------------------------
// tb_escape_sequence_line_editor - self-checking bench for the line editor
// Drives key, read and new-line requests with random idling on both sides,
// predicts every result with a behavioral copy of the editor and history ring,
// and compares each result field by field in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_escape_sequence_line_editor;

  localparam int LLEN  = 256;
  localparam int HDEP  = 8;
  localparam int NONE  = HDEP;  // no history entry selected

  typedef struct packed {
    logic [8:0] len;
    logic [8:0] cur;
    logic       done;
    logic       dirty;
    logic       clr;
    logic [7:0] rd;
    logic [1:0] phase;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic [1:0] command = lse_pkg::CMD_KEY;
  logic [7:0] key_byte = 8'd0;
  logic [7:0] read_index = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [8:0] line_length;
  logic [8:0] cursor_pos;
  logic       accepted;
  logic       redraw;
  logic       clear_screen;
  logic [7:0] read_data;
  logic [1:0] decoder_state;

  escape_sequence_line_editor uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .key_byte(key_byte), .read_index(read_index),
    .res_valid(res_valid), .res_stall(res_stall),
    .line_length(line_length), .cursor_pos(cursor_pos), .accepted(accepted),
    .redraw(redraw), .clear_screen(clear_screen), .read_data(read_data),
    .decoder_state(decoder_state)
  );

  always #10 clk = ~clk;

  // ---------------- editor shadow state ----------------
  logic [7:0]      ed_line [LLEN];
  int              ed_len, ed_cur, ed_done, ed_csi_num, ed_csi_closed;
  lse_pkg::phase_t ed_phase;
  logic [7:0]      hist_text [HDEP][LLEN];
  int              hist_len [HDEP];
  int              hist_newest, hist_count, hist_pos;
  bit              ed_dirty, ed_clr;

  outcome_t   pending_results[$];
  int         errors = 0;
  int         requests_sent = 0;
  int         results_seen = 0;
  bit         quiet = 1'b0;        // idling off for a stretch
  int         hold_cycles = 0;     // long receiver hold-off when nonzero

  function automatic void clear_line();
    for (int i = 0; i < LLEN; i++) ed_line[i] = 8'd0;
    ed_len = 0;
    ed_cur = 0;
  endfunction

  function automatic void recall_entry(input int age);
    int slot;
    slot = (hist_newest + HDEP - age) % HDEP;
    clear_line();
    for (int i = 0; i < hist_len[slot]; i++) ed_line[i] = hist_text[slot][i];
    ed_len = hist_len[slot];
    ed_cur = ed_len;
    ed_dirty = 1'b1;
  endfunction

  function automatic void history_up();
    if (hist_count == 0) return;
    if (hist_pos >= HDEP) hist_pos = 0;
    else if (hist_pos + 1 < hist_count) hist_pos++;
    recall_entry(hist_pos);
  endfunction

  function automatic void history_down();
    if (hist_pos >= HDEP) return;
    if (hist_pos == 0) begin
      hist_pos = NONE;
      clear_line();
      ed_dirty = 1'b1;
    end else begin
      hist_pos--;
      recall_entry(hist_pos);
    end
  endfunction

  function automatic void delete_at_cursor();
    if (ed_cur < ed_len) begin
      for (int i = ed_cur; i < ed_len - 1; i++) ed_line[i] = ed_line[i+1];
      ed_len--;
      ed_line[ed_len] = 8'd0;
      ed_dirty = 1'b1;
    end
  endfunction

  function automatic void commit_line();
    int slot;
    ed_done = 1;
    slot = (hist_count == 0) ? hist_newest : (hist_newest + 1) % HDEP;
    for (int i = 0; i < LLEN; i++) hist_text[slot][i] = ed_line[i];
    hist_len[slot] = ed_len;
    hist_newest = slot;
    if (hist_count < HDEP) hist_count++;
    hist_pos = NONE;
  endfunction

  function automatic void cursor_move(input int target);
    ed_cur = target;
    ed_dirty = 1'b1;
  endfunction

  function automatic void ground_key(input logic [7:0] c);
    if (c >= lse_pkg::KEY_PRINT_LO && c <= lse_pkg::KEY_PRINT_HI) begin
      if (ed_len >= LLEN) return;
      for (int i = ed_len; i > ed_cur; i--) ed_line[i] = ed_line[i-1];
      ed_line[ed_cur] = c;
      ed_cur++;
      ed_len++;
      ed_dirty = 1'b1;
      return;
    end
    case (c)
      lse_pkg::KEY_ESC: ed_phase = lse_pkg::PH_ESC;
      lse_pkg::KEY_CR, lse_pkg::KEY_LF: commit_line();
      lse_pkg::KEY_CTRL_B: if (ed_cur > 0) cursor_move(ed_cur - 1);
      lse_pkg::KEY_CTRL_F: if (ed_cur < ed_len) cursor_move(ed_cur + 1);
      lse_pkg::KEY_CTRL_A: cursor_move(0);
      lse_pkg::KEY_CTRL_E: cursor_move(ed_len);
      lse_pkg::KEY_CTRL_P: history_up();
      lse_pkg::KEY_CTRL_N: history_down();
      lse_pkg::KEY_BS, lse_pkg::KEY_DEL: begin
        if (ed_cur != 0) begin
          for (int i = ed_cur - 1; i < ed_len - 1; i++) ed_line[i] = ed_line[i+1];
          ed_len--;
          ed_line[ed_len] = 8'd0;
          ed_cur--;
          ed_dirty = 1'b1;
        end
      end
      lse_pkg::KEY_CTRL_U: begin
        for (int i = 0; i < ed_len - ed_cur; i++) ed_line[i] = ed_line[i+ed_cur];
        for (int i = ed_len - ed_cur; i < ed_len; i++) ed_line[i] = 8'd0;
        ed_len -= ed_cur;
        ed_cur = 0;
        ed_dirty = 1'b1;
      end
      lse_pkg::KEY_CTRL_K: begin
        for (int i = ed_cur; i < ed_len; i++) ed_line[i] = 8'd0;
        ed_len = ed_cur;
        ed_dirty = 1'b1;
      end
      lse_pkg::KEY_CTRL_D: begin
        if (ed_len == 0) begin
          // empty line turns into "exit" and is accepted
          ed_line[0] = lse_pkg::EXIT_WORD[31:24];
          ed_line[1] = lse_pkg::EXIT_WORD[23:16];
          ed_line[2] = lse_pkg::EXIT_WORD[15:8];
          ed_line[3] = lse_pkg::EXIT_WORD[7:0];
          ed_len = 4;
          ed_dirty = 1'b1;
          commit_line();
        end else delete_at_cursor();
      end
      lse_pkg::KEY_CTRL_L: begin
        ed_clr = 1'b1;
        ed_dirty = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void csi_key(input logic [7:0] c);
    if (c < lse_pkg::CSI_FINAL_MIN) begin
      if (!ed_csi_closed && c >= lse_pkg::KEY_DIGIT0 && c <= lse_pkg::KEY_DIGIT9) begin
        ed_csi_num = ed_csi_num * 10 + (c - lse_pkg::KEY_DIGIT0);
        if (ed_csi_num > lse_pkg::CSI_NUM_MAX) ed_csi_num = lse_pkg::CSI_NUM_MAX;
      end else ed_csi_closed = 1;
      return;
    end
    ed_phase = lse_pkg::PH_GROUND;
    case (c)
      lse_pkg::CSI_UP:    history_up();
      lse_pkg::CSI_DOWN:  history_down();
      lse_pkg::CSI_RIGHT: if (ed_cur < ed_len) cursor_move(ed_cur + 1);
      lse_pkg::CSI_LEFT:  if (ed_cur > 0) cursor_move(ed_cur - 1);
      lse_pkg::CSI_HOME:  cursor_move(0);
      lse_pkg::CSI_END:   cursor_move(ed_len);
      lse_pkg::KEY_TILDE: begin
        if (ed_csi_num == lse_pkg::TILDE_HOME1 || ed_csi_num == lse_pkg::TILDE_HOME2)
          cursor_move(0);
        else if (ed_csi_num == lse_pkg::TILDE_END1 || ed_csi_num == lse_pkg::TILDE_END2)
          cursor_move(ed_len);
        else if (ed_csi_num == lse_pkg::TILDE_DEL) delete_at_cursor();
      end
      default: ;
    endcase
  endfunction

  // Applies one request to the shadow editor and returns the expected result.
  function automatic outcome_t edit_step(input logic [1:0] cmd, input logic [7:0] key,
                                         input logic [7:0] idx);
    outcome_t o;
    int rd;
    rd = 0;
    ed_dirty = 1'b0;
    ed_clr = 1'b0;
    if (cmd == lse_pkg::CMD_KEY) begin
      if (!ed_done) begin
        if (ed_phase == lse_pkg::PH_ESC) begin
          if (key == lse_pkg::KEY_LBRACKET) begin
            ed_phase = lse_pkg::PH_CSI;
            ed_csi_num = 0;
            ed_csi_closed = 0;
          end else begin
            ed_phase = lse_pkg::PH_GROUND;
            ground_key(key);
          end
        end else if (ed_phase == lse_pkg::PH_CSI) csi_key(key);
        else ground_key(key);
      end
    end else if (cmd == lse_pkg::CMD_READ) begin
      if (idx < ed_len) rd = ed_line[idx];
    end else if (cmd == lse_pkg::CMD_NEW) begin
      clear_line();
      ed_phase = lse_pkg::PH_GROUND;
      ed_done = 0;
      ed_dirty = 1'b1;
    end
    o.len = 9'(ed_len);
    o.cur = 9'(ed_cur);
    o.done = ed_done[0];
    o.dirty = ed_dirty;
    o.clr = ed_clr;
    o.rd = 8'(rd);
    o.phase = ed_phase;
    return o;
  endfunction

  // ---------------- request side ----------------
  // valid stays up from one request to the next unless the sender idles
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] key,
                              input logic [7:0] idx);
    while (!quiet && $urandom_range(99) < 15) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    command    <= cmd;
    key_byte   <= key;
    read_index <= idx;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_results.push_back(edit_step(cmd, key, idx));
    requests_sent++;
  endtask

  task automatic send_key(input logic [7:0] key);
    send_request(lse_pkg::CMD_KEY, key, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input int n);
    for (int i = 0; i < n; i++)
      send_key(8'($urandom_range(lse_pkg::KEY_PRINT_LO, lse_pkg::KEY_PRINT_HI)));
  endtask

  task automatic send_csi(input logic [7:0] fin, input int num);
    send_key(lse_pkg::KEY_ESC);
    send_key(lse_pkg::KEY_LBRACKET);
    if (num >= 0) begin
      string s;
      s = $sformatf("%0d", num);
      for (int i = 0; i < s.len(); i++) send_key(s[i]);
    end
    send_key(fin);
  endtask

  // ---------------- result side ----------------
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("ERROR result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      res_stall <= 1'b1;
      hold_cycles--;
    end else res_stall <= !quiet && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      outcome_t w;
      if (pending_results.size() == 0) begin
        errors++;
        $display("ERROR unexpected result with none pending");
      end else begin
        w = pending_results.pop_front();
        if (line_length !== w.len) report_mismatch("line_length", line_length, w.len);
        if (cursor_pos !== w.cur) report_mismatch("cursor_pos", cursor_pos, w.cur);
        if (accepted !== w.done) report_mismatch("accepted", accepted, w.done);
        if (redraw !== w.dirty) report_mismatch("redraw", redraw, w.dirty);
        if (clear_screen !== w.clr) report_mismatch("clear_screen", clear_screen, w.clr);
        if (read_data !== w.rd) report_mismatch("read_data", read_data, w.rd);
        if (decoder_state !== w.phase)
          report_mismatch("decoder_state", decoder_state, w.phase);
      end
      results_seen++;
    end
  end

  // ---------------- tests ----------------
  task automatic test_editing_keys();
    send_key(lse_pkg::KEY_CTRL_D);        // empty line becomes exit
    send_key(lse_pkg::KEY_CTRL_P);        // ignored once accepted
    send_request(lse_pkg::CMD_READ, 8'd0, 8'd0);
    send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
    send_key(lse_pkg::KEY_PRINT_LO);
    send_key(lse_pkg::KEY_PRINT_HI);
    send_key(8'hFF);                      // high bytes are ignored
    send_key(8'h09);                      // tab ignored
    send_key(lse_pkg::KEY_CTRL_B);
    send_key(lse_pkg::KEY_CTRL_A);
    send_key(lse_pkg::KEY_CTRL_F);
    send_key(lse_pkg::KEY_CTRL_E);
    send_key(lse_pkg::KEY_BS);
    send_text(3);
    send_key(lse_pkg::KEY_CTRL_A);
    send_key(lse_pkg::KEY_CTRL_D);        // delete at cursor
    send_key(lse_pkg::KEY_CTRL_F);
    send_key(lse_pkg::KEY_CTRL_U);
    send_key(lse_pkg::KEY_CTRL_K);
    send_key(lse_pkg::KEY_DEL);
    send_key(lse_pkg::KEY_CTRL_L);
    send_request(lse_pkg::CMD_READ, 8'd0, 8'd255);
    send_request(2'd3, 8'hAA, 8'h55);     // unused command
    send_key(lse_pkg::KEY_CR);
  endtask

  task automatic test_escape_sequences();
    send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
    send_text(5);
    send_csi(lse_pkg::CSI_LEFT, -1);
    send_csi(lse_pkg::CSI_HOME, -1);
    send_csi(lse_pkg::CSI_RIGHT, -1);
    send_csi(lse_pkg::CSI_END, -1);
    send_csi(lse_pkg::KEY_TILDE, 1);
    send_csi(lse_pkg::KEY_TILDE, 4);
    send_csi(lse_pkg::KEY_TILDE, 7);
    send_csi(lse_pkg::KEY_TILDE, 8);
    send_csi(lse_pkg::KEY_TILDE, 3);
    send_csi(lse_pkg::KEY_TILDE, 99999);  // number saturates
    send_key(lse_pkg::KEY_ESC);           // escape then plain key
    send_key(8'h41);
    send_key(lse_pkg::KEY_ESC);
    send_key(lse_pkg::KEY_LBRACKET);
    send_key(8'h32);
    send_key(8'h3B);                      // closes the number
    send_key(8'h35);                      // later digit ignored
    send_key(lse_pkg::KEY_TILDE);
    send_csi(8'h7A, -1);                  // unknown final
    send_key(lse_pkg::KEY_LF);
  endtask

  task automatic test_history();
    for (int n = 0; n < HDEP + 3; n++) begin
      send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
      send_text($urandom_range(0, 6));
      send_key(lse_pkg::KEY_CR);
    end
    send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
    for (int i = 0; i < HDEP + 2; i++) send_key(lse_pkg::KEY_CTRL_P);
    for (int i = 0; i < 3; i++)
      send_request(lse_pkg::CMD_READ, 8'd0, 8'($urandom_range(0, 7)));
    for (int i = 0; i < HDEP + 2; i++) send_csi(lse_pkg::CSI_DOWN, -1);
    send_csi(lse_pkg::CSI_UP, -1);
  endtask

  task automatic test_full_line();
    send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
    quiet = 1'b1;                         // no idling through this stretch
    send_text(LLEN + 2);                  // extra bytes dropped when full
    quiet = 1'b0;
    send_request(lse_pkg::CMD_READ, 8'd0, 8'd255);
    send_key(lse_pkg::KEY_CTRL_A);
    send_key(lse_pkg::KEY_CTRL_D);
    send_key(lse_pkg::KEY_CTRL_K);
  endtask

  task automatic test_backpressure();
    send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
    hold_cycles = 300;                    // receiver goes quiet for a long time
    send_text(6);
    send_key(lse_pkg::KEY_CTRL_U);
  endtask

  task automatic test_random_sessions();
    int sent;
    int r;
    sent = 0;
    while (sent < 40) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send_text($urandom_range(1, 4));
        sent += 2;
      end else if (r < 55) begin
        logic [7:0] fins [7];
        fins = '{lse_pkg::CSI_UP, lse_pkg::CSI_DOWN, lse_pkg::CSI_RIGHT, lse_pkg::CSI_LEFT,
                 lse_pkg::CSI_HOME, lse_pkg::CSI_END, lse_pkg::KEY_TILDE};
        send_csi(fins[$urandom_range(6)],
                 ($urandom_range(3) == 0) ? -1 : $urandom_range(0, 9));
        sent += 4;
      end else if (r < 75) begin
        logic [7:0] ctl [13];
        ctl = '{lse_pkg::KEY_CTRL_A, lse_pkg::KEY_CTRL_B, lse_pkg::KEY_CTRL_D,
                lse_pkg::KEY_CTRL_E, lse_pkg::KEY_CTRL_F, lse_pkg::KEY_BS,
                lse_pkg::KEY_CTRL_K, lse_pkg::KEY_CTRL_L, lse_pkg::KEY_CTRL_N,
                lse_pkg::KEY_CTRL_P, lse_pkg::KEY_CTRL_U, lse_pkg::KEY_DEL,
                lse_pkg::KEY_ESC};
        send_key(ctl[$urandom_range(12)]);
        sent++;
      end else if (r < 82) begin
        send_request(lse_pkg::CMD_READ, 8'd0, 8'($urandom_range(0, 12)));
        sent++;
      end else if (r < 88) begin
        send_key(8'($urandom_range(255)));  // noise
        sent++;
      end else if (r < 94) begin
        send_key(($urandom_range(1)) ? lse_pkg::KEY_CR : lse_pkg::KEY_LF);
        send_request(lse_pkg::CMD_NEW, 8'd0, 8'd0);
        sent += 2;
      end else begin
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  // ---------------- sequence ----------------
  initial begin
    int wait_cycles;
    clear_line();
    ed_phase = lse_pkg::PH_GROUND;
    ed_done = 0;
    ed_csi_num = 0;
    ed_csi_closed = 0;
    hist_newest = 0;
    hist_count = 0;
    hist_pos = NONE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_editing_keys();
    test_escape_sequences();
    test_history();
    test_full_line();
    test_backpressure();
    test_random_sessions();
    cmd_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LLEN + 20) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("ERROR %0d results never arrived", pending_results.size());
    end
    $display("Covered %0d requests: editing keys, CSI sequences, history ring,",
             requests_sent);
    $display("full line, receiver hold-off and random sessions; %0d results checked",
             results_seen);
    if (errors == 0) $display("escape_sequence_line_editor test passed");
    else $display("escape_sequence_line_editor test failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("escape_sequence_line_editor test failed");
    $finish;
  end

endmodule

`default_nettype wire
